/* hw/rtl/mm2h_pkg.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 byte stream hash: shared package
// Constants of the hash, the datapath operation codes and the command and
// status structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mm2h_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int          MIX_SHIFT   = 24;
   localparam int          FIN_SHIFT_A = 13;
   localparam int          FIN_SHIFT_B = 15;
   localparam logic [31:0] SEED_RESET  = 32'd702741;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_MIX_A,
      OP_MIX_B,
      OP_MIX_C,
      OP_TAIL,
      OP_FIN,
      OP_DELIVER
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic mix_pending;
      logic last;
      logic out_free;
   } dp_status_type;

endpackage

/* hw/rtl/mm2h_datapath.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 byte stream hash: datapath
// Running hash, partial word, byte counters, one shared 32x32 multiplier and
// the result register. Each operation is selected by the controller.
// ----------------------------------------------------------------------------
module mm2h_datapath
   import mm2h_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          csr_write_enable,
   input  logic [31:0]   csr_write_data,
   input  logic [7:0]    req_data_byte,
   input  logic          req_has_byte,
   input  logic          req_first,
   input  logic          req_last,
   input  logic [31:0]   req_message_length,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [31:0]   rsp_hash,
   output logic          rsp_length_mismatch
);

   logic [31:0] seed_ff, seed_in;
   logic [31:0] hash_state_ff, hash_state_in;
   logic [23:0] word_buffer_ff, word_buffer_in;
   logic [1:0]  byte_phase_ff, byte_phase_in;
   logic [31:0] bytes_seen_ff, bytes_seen_in;
   logic [31:0] expected_length_ff, expected_length_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] fin_ff, fin_in;
   logic        mix_pending_ff, mix_pending_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic        rsp_mismatch_ff, rsp_mismatch_in;

   logic [31:0] mul_a;
   logic [31:0] mul_p;
   logic [23:0] eff_buffer;
   logic [1:0]  eff_phase;
   logic [31:0] eff_seen;
   logic [31:0] seen_inc;

   // Shared multiplier: only the low word of the product is kept.
   always_comb begin
      case (cmd.op)
         OP_MIX_A: mul_a = key_ff;
         OP_MIX_B: mul_a = key_ff ^ (key_ff >> MIX_SHIFT);
         OP_MIX_C: mul_a = hash_state_ff;
         OP_TAIL:  mul_a = hash_state_ff ^ {8'd0, word_buffer_ff};
         OP_FIN:   mul_a = fin_ff ^ (fin_ff >> FIN_SHIFT_A);
         default:  mul_a = '0;
      endcase
   end

   assign mul_p = mul_a * MIX_MUL;

   // A first item restarts the message before its byte is taken in.
   assign eff_buffer = req_first ? '0 : word_buffer_ff;
   assign eff_phase  = req_first ? '0 : byte_phase_ff;
   assign eff_seen   = req_first ? '0 : bytes_seen_ff;
   assign seen_inc   = (eff_seen != '1) ? eff_seen + 32'd1 : eff_seen;

   always_comb begin
      seed_in            = seed_ff;
      hash_state_in      = hash_state_ff;
      word_buffer_in     = word_buffer_ff;
      byte_phase_in      = byte_phase_ff;
      bytes_seen_in      = bytes_seen_ff;
      expected_length_in = expected_length_ff;
      key_in             = key_ff;
      fin_in             = fin_ff;
      mix_pending_in     = mix_pending_ff;
      last_in            = last_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_hash_in        = rsp_hash_ff;
      rsp_mismatch_in    = rsp_mismatch_ff;

      if (csr_write_enable) begin
         seed_in = csr_write_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (cmd.op)
         OP_ACCEPT: begin
            last_in            = req_last;
            hash_state_in      = req_first ? (seed_ff ^ req_message_length) : hash_state_ff;
            expected_length_in = req_first ? req_message_length : expected_length_ff;
            word_buffer_in     = eff_buffer;
            byte_phase_in      = eff_phase;
            bytes_seen_in      = eff_seen;
            mix_pending_in     = 1'b0;
            if (req_has_byte) begin
               bytes_seen_in = seen_inc;
               case (eff_phase)
                  2'd0: begin
                     word_buffer_in = {eff_buffer[23:8], req_data_byte};
                     byte_phase_in  = 2'd1;
                  end
                  2'd1: begin
                     word_buffer_in = {eff_buffer[23:16], req_data_byte, eff_buffer[7:0]};
                     byte_phase_in  = 2'd2;
                  end
                  2'd2: begin
                     word_buffer_in = {req_data_byte, eff_buffer[15:0]};
                     byte_phase_in  = 2'd3;
                  end
                  default: begin
                     // Fourth byte completes a little-endian word for mixing.
                     key_in         = {req_data_byte, eff_buffer};
                     word_buffer_in = '0;
                     byte_phase_in  = '0;
                     mix_pending_in = 1'b1;
                  end
               endcase
            end
         end
         OP_MIX_A: key_in = mul_p;
         OP_MIX_B: key_in = mul_p;
         OP_MIX_C: begin
            hash_state_in  = mul_p ^ key_ff;
            mix_pending_in = 1'b0;
         end
         OP_TAIL: fin_in = (byte_phase_ff != '0) ? mul_p : hash_state_ff;
         OP_FIN:  fin_in = mul_p;
         OP_DELIVER: begin
            rsp_valid_in    = 1'b1;
            rsp_hash_in     = fin_ff ^ (fin_ff >> FIN_SHIFT_B);
            rsp_mismatch_in = (bytes_seen_ff != expected_length_ff);
            word_buffer_in  = '0;
            byte_phase_in   = '0;
            bytes_seen_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff            <= SEED_RESET;
         hash_state_ff      <= '0;
         word_buffer_ff     <= '0;
         byte_phase_ff      <= '0;
         bytes_seen_ff      <= '0;
         expected_length_ff <= '0;
         mix_pending_ff     <= 1'b0;
         last_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         seed_ff            <= seed_in;
         hash_state_ff      <= hash_state_in;
         word_buffer_ff     <= word_buffer_in;
         byte_phase_ff      <= byte_phase_in;
         bytes_seen_ff      <= bytes_seen_in;
         expected_length_ff <= expected_length_in;
         mix_pending_ff     <= mix_pending_in;
         last_ff            <= last_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      fin_ff          <= fin_in;
      rsp_hash_ff     <= rsp_hash_in;
      rsp_mismatch_ff <= rsp_mismatch_in;
   end

   assign status.mix_pending = mix_pending_ff;
   assign status.last        = last_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hash            = rsp_hash_ff;
   assign rsp_length_mismatch = rsp_mismatch_ff;

endmodule

/* hw/rtl/mm2h_ctrl.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 byte stream hash: controller
// Sequences the word mix, the tail and finish steps on the shared multiplier
// of the datapath, and the result load.
// ----------------------------------------------------------------------------
module mm2h_ctrl
   import mm2h_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b00000001,
      ST_DISPATCH = 8'b00000010,
      ST_MIX_A    = 8'b00000100,
      ST_MIX_B    = 8'b00001000,
      ST_MIX_C    = 8'b00010000,
      ST_TAIL     = 8'b00100000,
      ST_FIN      = 8'b01000000,
      ST_DELIVER  = 8'b10000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.mix_pending) begin
               state_in = ST_MIX_A;
            end else if (status.last) begin
               state_in = ST_TAIL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MIX_A: begin
            cmd.op   = OP_MIX_A;
            state_in = ST_MIX_B;
         end
         ST_MIX_B: begin
            cmd.op   = OP_MIX_B;
            state_in = ST_MIX_C;
         end
         ST_MIX_C: begin
            cmd.op   = OP_MIX_C;
            state_in = status.last ? ST_TAIL : ST_IDLE;
         end
         ST_TAIL: begin
            cmd.op   = OP_TAIL;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op   = OP_FIN;
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            // Hold the finished value until the result register is free.
            if (status.out_free) begin
               cmd.op   = OP_DELIVER;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/murmur2_byte_stream_hash.sv */
// ----------------------------------------------------------------------------
// MurmurHash2 byte stream hash: top level
// Hashes a message fed at most one byte per transfer with 32-bit MurmurHash2.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries at most one byte per transfer. The transfer
// marked req_first loads the state with seed XOR req_message_length; the
// transfer marked req_last produces one result on the rsp_ channel, with the
// hash and a flag that the byte count differed from the stated length. The
// seed must be written through csr_write_enable / csr_write_data only while
// the block is idle; the block does not enforce this. Each item passes a
// dispatch step; one that completes a 32-bit word then takes the word mix,
// three passes through the single shared 32x32 multiplier. A last item then
// takes the tail and finish steps and the result load before rsp_valid
// rises. req_stall is high while an item is being worked on. The result sits
// in an output register; a stalled result holds, and the next message may
// already be taken in, but a later result waits until the earlier one has
// been transferred. Reset clears the control state, counters and running
// hash and sets the seed to its default; no result is pending after reset.
// ----------------------------------------------------------------------------
module murmur2_byte_stream_hash
   import mm2h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_first,
   input  logic        req_last,
   input  logic [31:0] req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash,
   output logic        rsp_length_mismatch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mm2h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mm2h_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_data_byte       (req_data_byte),
      .req_has_byte        (req_has_byte),
      .req_first           (req_first),
      .req_last            (req_last),
      .req_message_length  (req_message_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hash            (rsp_hash),
      .rsp_length_mismatch (rsp_length_mismatch)
   );

`ifndef ASSERT_OFF
   // Each accepted item stalls the input side in the cycle after it is taken.
   a_stall_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("input accepted on consecutive cycles");

   // The block comes out of reset ready to take an item.
   a_ready_after_reset: assert property (
      @(posedge clock) disable iff (reset)
      $past(reset) |-> !req_stall
   ) else $error("input stalled directly after reset");

   // A result only appears after the controller has finished an item.
   a_result_source: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall
   ) else $error("result appeared while an item was still in progress");
`endif

endmodule
